// ----- design/multilinear_grid_interpolator_defines.svh -----
// Assertion macros for the multilinear grid interpolator.
`ifndef MULTILINEAR_GRID_INTERPOLATOR_DEFINES_SVH
`define MULTILINEAR_GRID_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GMI_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmi assertion failed");
`define GMI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmi assertion failed");
`else
`define GMI_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define GMI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/gmi_pkg.sv -----
// Shared constants, codes and types of the multilinear grid interpolator.
`timescale 1ns / 1ps
package gmi_pkg;
    localparam int MAX_DIMS_DEF  = 3;
    localparam int MAX_KNOTS_DEF = 16;
    localparam int HW_DIMS       = 3;
    localparam int NODE_DEPTH    = 4096;
    localparam int NODE_AW       = 12;
    localparam int IDX_MAX_W     = 6;
    localparam int NPTS_W        = IDX_MAX_W + 1;

    localparam logic [1:0] REQ_KNOT  = 2'd0;
    localparam logic [1:0] REQ_NODE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [2:0] CFG_NUM_DIMS = 3'd0;
    localparam logic [2:0] CFG_POINTS0  = 3'd1;
    localparam logic [2:0] CFG_POINTS1  = 3'd2;
    localparam logic [2:0] CFG_POINTS2  = 3'd3;
    localparam logic [2:0] CFG_OUT_MODE = 3'd4;

    localparam logic [2:0] MODE_NAN      = 3'd0;
    localparam logic [2:0] MODE_ZERO     = 3'd1;
    localparam logic [2:0] MODE_EXTRAP   = 3'd2;
    localparam logic [2:0] MODE_CLAMP    = 3'd3;
    localparam logic [2:0] MODE_PERIODIC = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NAN  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic signed [63:0] ONE_U    = 64'sd1 <<< 30;
    localparam logic signed [64:0] WIDE_POS = 65'sd1 <<< 61;
    localparam logic signed [64:0] WIDE_NEG = -(65'sd1 <<< 61);

    typedef struct packed {
        logic [1:0]            status;
        logic [IDX_MAX_W-1:0]  k;
        logic signed [63:0]    u;
    } lane_res_t;
endpackage

// ----- design/multilinear_grid_interpolator.sv -----
// Top level of the multilinear grid interpolator: registers, lanes and merge.
//
// Usage: items arrive on the command channel. An item transfers at a rising
// edge with start high and busy low. Knot loads (req_type 0) and node loads
// (req_type 1) are written at that edge and produce no result; busy stays low.
// A query (req_type 2) raises busy; one lane per dimension searches its knot
// table, folds periodic points and divides out the weight one bit a cycle.
// The merge stage then fetches 2^nd corners from the node table and blends
// them with one time-shared multiplier (four 32x32 partial products).
// In periodic mode a point outside the grid is folded by a first divider pass
// before the search and weight division. When a NaN flag or zero mode
// decides the result, the merge skips the corner fetch and blend.
// The result shows on interp_value/result_nan for exactly one cycle with
// done high; the receiver cannot hold it off. One query at a time.
// Configuration writes transfer whenever cfg_valid is high (cfg_ready is
// tied high) and must only be issued while the block is idle.
// Reset clears control and configuration; table contents are undefined
// until written.
`timescale 1ns / 1ps
`include "multilinear_grid_interpolator_defines.svh"
module multilinear_grid_interpolator #(
    parameter int MAX_DIMS  = gmi_pkg::MAX_DIMS_DEF,
    parameter int MAX_KNOTS = gmi_pkg::MAX_KNOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [1:0]         dim_select,
    input  logic [11:0]        entry_index,
    input  logic signed [31:0] load_data,
    input  logic signed [31:0] coord_a,
    input  logic signed [31:0] coord_b,
    input  logic signed [31:0] coord_c,
    input  logic [2:0]         coord_nan_mask,
    output logic               done,
    output logic signed [31:0] interp_value,
    output logic               result_nan,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [4:0]         cfg_data
);
    import gmi_pkg::*;

    localparam int LANES = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
    localparam int KW    = $clog2(MAX_KNOTS);
    localparam int NW    = $clog2(MAX_KNOTS + 1);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_LANES = 2'd1;
    localparam logic [1:0] T_MERGE = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  num_dims_reg;
    logic [4:0]  points_reg [HW_DIMS];
    logic [2:0]  out_mode_reg;

    logic              accept, lane_start, merge_start, merge_done;
    logic [1:0]        nd;
    logic [NPTS_W-1:0] n_eff [HW_DIMS];
    logic [LANES-1:0]  lane_done;
    lane_res_t         lane_res [LANES];
    lane_res_t         res_pad  [HW_DIMS];
    logic signed [31:0] coords  [HW_DIMS];

    assign accept     = start && !busy;
    assign lane_start = accept && (req_type == REQ_QUERY);
    assign busy       = (state_reg != T_IDLE);
    assign cfg_ready  = 1'b1;
    assign coords[0]  = coord_a;
    assign coords[1]  = coord_b;
    assign coords[2]  = coord_c;

    // effective dimension count and knot counts
    always_comb
    begin
        nd = (num_dims_reg == 2'd0) ? 2'd1 : num_dims_reg;
        if (nd > 2'(LANES))
        begin
            nd = 2'(LANES);
        end
        for (int j = 0; j < HW_DIMS; j++)
        begin
            if (points_reg[j] < 5'd2)
            begin
                n_eff[j] = NPTS_W'(2);
            end
            else if (NPTS_W'(points_reg[j]) > NPTS_W'(MAX_KNOTS))
            begin
                n_eff[j] = NPTS_W'(MAX_KNOTS);
            end
            else
            begin
                n_eff[j] = NPTS_W'(points_reg[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= 2'd1;
            points_reg   <= '{default: 5'd2};
            out_mode_reg <= MODE_NAN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUM_DIMS: num_dims_reg  <= cfg_data[1:0];
                CFG_POINTS0:  points_reg[0] <= cfg_data;
                CFG_POINTS1:  points_reg[1] <= cfg_data;
                CFG_POINTS2:  points_reg[2] <= cfg_data;
                CFG_OUT_MODE: out_mode_reg  <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // sequence one query: lanes in parallel, then the merge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (lane_start)
                    begin
                        state_reg <= T_LANES;
                    end
                end
                T_LANES:
                begin
                    if (&lane_done)
                    begin
                        state_reg <= T_MERGE;
                    end
                end
                T_MERGE:
                begin
                    if (merge_done)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign merge_start = (state_reg == T_LANES) && (&lane_done);

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        gmi_lane #(.MAX_KNOTS(MAX_KNOTS)) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (lane_start),
            .nan_flag (coord_nan_mask[j]),
            .coord    (coords[j]),
            .n_pts    (n_eff[j][NW-1:0]),
            .mode     (out_mode_reg),
            .wr_en    (accept && req_type == REQ_KNOT && dim_select == 2'(j)
                       && entry_index < 12'(MAX_KNOTS)),
            .wr_addr  (entry_index[KW-1:0]),
            .wr_data  (load_data),
            .res      (lane_res[j]),
            .done     (lane_done[j])
        );
    end

    for (genvar j = 0; j < HW_DIMS; j++)
    begin : g_pad
        if (j < LANES)
        begin : g_used
            assign res_pad[j] = lane_res[j];
        end
        else
        begin : g_absent
            assign res_pad[j] = '0;
        end
    end

    gmi_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (merge_start),
        .lane_res     (res_pad),
        .n_pts        (n_eff),
        .nd           (nd),
        .wr_en        (accept && req_type == REQ_NODE),
        .wr_addr      (entry_index),
        .wr_data      (load_data),
        .done         (merge_done),
        .interp_value (interp_value),
        .result_nan   (result_nan)
    );

    assign done = merge_done;

    `GMI_ASSERT_NEXT(a_done_frees, clk, rst_n, done, !busy)
    `GMI_ASSERT_IMPLY(a_nan_zero, clk, rst_n, done && result_nan, interp_value == 32'sd0)
    `GMI_ASSERT_NEXT(a_load_idle, clk, rst_n, start && !busy && req_type != REQ_QUERY, !busy)
    `GMI_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && req_type == REQ_QUERY, busy)
endmodule

// ----- design/gmi_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module gmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/gmi_lane.sv -----
// One dimension lane: knot table, interval search, fold and serial weight division.
`timescale 1ns / 1ps
module gmi_lane #(
    parameter int MAX_KNOTS = gmi_pkg::MAX_KNOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         nan_flag,
    input  logic signed [31:0]           coord,
    input  logic [$clog2(MAX_KNOTS+1)-1:0] n_pts,
    input  logic [2:0]                   mode,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_KNOTS)-1:0] wr_addr,
    input  logic [31:0]                  wr_data,
    output gmi_pkg::lane_res_t           res,
    output logic                         done
);
    import gmi_pkg::*;

    localparam int KW = $clog2(MAX_KNOTS);
    localparam int NW = $clog2(MAX_KNOTS + 1);
    localparam logic [5:0] DIV_STEPS = 6'd62;

    localparam logic [3:0] L_IDLE  = 4'd0;
    localparam logic [3:0] L_X0    = 4'd1;
    localparam logic [3:0] L_XL    = 4'd2;
    localparam logic [3:0] L_CHK   = 4'd3;
    localparam logic [3:0] L_SADDR = 4'd4;
    localparam logic [3:0] L_SCMP  = 4'd5;
    localparam logic [3:0] L_KLO   = 4'd6;
    localparam logic [3:0] L_KHI   = 4'd7;
    localparam logic [3:0] L_WGT   = 4'd8;
    localparam logic [3:0] L_DIV   = 4'd9;
    localparam logic [3:0] L_DEND  = 4'd10;

    logic [3:0]         state_reg;
    logic signed [32:0] t_reg;
    logic signed [32:0] x0_reg, xl_reg, lo_val_reg;
    logic [KW-1:0]      lo_reg, hi_reg;
    logic [31:0]        rem_reg, den_reg;
    logic [61:0]        num_reg, quo_reg;
    logic [5:0]         cnt_reg;
    logic               neg_reg, per_reg, done_reg;
    logic [1:0]         status_reg;
    logic signed [63:0] u_reg;

    logic [KW-1:0]      raddr, mid, nm1, nm2;
    logic [NW-1:0]      nm1_w, nm2_w;
    logic [KW:0]        mid_sum;
    logic [31:0]        rdata;
    logic signed [32:0] knot_v, len_v, diff_v, den_v, wdiff_v;
    logic [32:0]        trial, shifted;

    gmi_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knots (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        nm1_w   = n_pts - NW'(1);
        nm2_w   = n_pts - NW'(2);
        nm1     = nm1_w[KW-1:0];
        nm2     = nm2_w[KW-1:0];
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = mid_sum[KW:1];
        knot_v  = {rdata[31], rdata};
        len_v   = knot_v - x0_reg;
        diff_v  = t_reg - x0_reg;
        den_v   = knot_v - lo_val_reg;
        wdiff_v = t_reg - lo_val_reg;
        shifted = {rem_reg, num_reg[61]};
        trial   = shifted - {1'b0, den_reg};
        case (state_reg)
            L_XL:    raddr = nm1;
            L_SADDR: raddr = mid;
            L_KLO:   raddr = lo_reg;
            L_KHI:   raddr = lo_reg + KW'(1);
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= L_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        t_reg <= {coord[31], coord};
                        if (nan_flag)
                        begin
                            status_reg <= ST_NAN;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= L_X0;
                        end
                    end
                end
                L_X0:
                begin
                    state_reg <= L_XL;
                end
                L_XL:
                begin
                    x0_reg    <= knot_v;
                    state_reg <= L_CHK;
                end
                L_CHK:
                begin
                    xl_reg <= knot_v;
                    if (x0_reg <= t_reg && t_reg <= knot_v)
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= nm1;
                        state_reg <= L_SADDR;
                    end
                    else
                    begin
                        case (mode)
                            MODE_ZERO:
                            begin
                                status_reg <= ST_ZERO;
                                done_reg   <= 1'b1;
                                state_reg  <= L_IDLE;
                            end
                            MODE_EXTRAP:
                            begin
                                lo_reg    <= (t_reg < x0_reg) ? '0 : nm2;
                                state_reg <= L_KLO;
                            end
                            MODE_CLAMP:
                            begin
                                lo_reg     <= (t_reg < x0_reg) ? '0 : nm2;
                                u_reg      <= (t_reg < x0_reg) ? 64'sd0 : ONE_U;
                                status_reg <= ST_OK;
                                done_reg   <= 1'b1;
                                state_reg  <= L_IDLE;
                            end
                            MODE_PERIODIC:
                            begin
                                if (len_v <= 33'sd0)
                                begin
                                    t_reg     <= x0_reg;
                                    lo_reg    <= '0;
                                    state_reg <= L_KLO;
                                end
                                else
                                begin
                                    // fold by the grid period: remainder of |t - x0|
                                    num_reg   <= {30'd0, diff_v[32] ? 32'(-diff_v) : diff_v[31:0]};
                                    den_reg   <= len_v[31:0];
                                    neg_reg   <= diff_v[32];
                                    per_reg   <= 1'b1;
                                    rem_reg   <= '0;
                                    cnt_reg   <= DIV_STEPS;
                                    state_reg <= L_DIV;
                                end
                            end
                            default:
                            begin
                                status_reg <= ST_NAN;
                                done_reg   <= 1'b1;
                                state_reg  <= L_IDLE;
                            end
                        endcase
                    end
                end
                L_SADDR:
                begin
                    if ({1'b0, hi_reg} - {1'b0, lo_reg} > (KW+1)'(1))
                    begin
                        state_reg <= L_SCMP;
                    end
                    else
                    begin
                        state_reg <= L_KLO;
                    end
                end
                L_SCMP:
                begin
                    if (t_reg <= knot_v)
                    begin
                        hi_reg <= mid;
                    end
                    else
                    begin
                        lo_reg <= mid;
                    end
                    state_reg <= L_SADDR;
                end
                L_KLO:
                begin
                    state_reg <= L_KHI;
                end
                L_KHI:
                begin
                    lo_val_reg <= knot_v;
                    state_reg  <= L_WGT;
                end
                L_WGT:
                begin
                    if (den_v > 33'sd0)
                    begin
                        num_reg   <= {(wdiff_v[32] ? 32'(-wdiff_v) : wdiff_v[31:0]), 30'd0};
                        den_reg   <= den_v[31:0];
                        neg_reg   <= wdiff_v[32];
                        per_reg   <= 1'b0;
                        rem_reg   <= '0;
                        cnt_reg   <= DIV_STEPS;
                        state_reg <= L_DIV;
                    end
                    else
                    begin
                        u_reg      <= 64'sd0;
                        status_reg <= ST_OK;
                        done_reg   <= 1'b1;
                        state_reg  <= L_IDLE;
                    end
                end
                L_DIV:
                begin
                    // one quotient bit per cycle, restoring
                    if (!trial[32])
                    begin
                        rem_reg <= trial[31:0];
                    end
                    else
                    begin
                        rem_reg <= shifted[31:0];
                    end
                    quo_reg <= {quo_reg[60:0], ~trial[32]};
                    num_reg <= {num_reg[60:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= L_DEND;
                    end
                end
                L_DEND:
                begin
                    if (per_reg)
                    begin
                        t_reg     <= neg_reg ? xl_reg - $signed({1'b0, rem_reg})
                                             : x0_reg + $signed({1'b0, rem_reg});
                        lo_reg    <= '0;
                        hi_reg    <= nm1;
                        state_reg <= L_SADDR;
                    end
                    else
                    begin
                        u_reg      <= neg_reg ? -$signed({2'b00, quo_reg})
                                              : $signed({2'b00, quo_reg});
                        status_reg <= ST_OK;
                        done_reg   <= 1'b1;
                        state_reg  <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign res.status = status_reg;
    assign res.k      = IDX_MAX_W'(lo_reg);
    assign res.u      = u_reg;
    assign done       = done_reg;
endmodule

// ----- design/gmi_merge.sv -----
// Merge stage: node table, corner fetch and serial blend of the lane weights.
`timescale 1ns / 1ps
module gmi_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  gmi_pkg::lane_res_t          lane_res [gmi_pkg::HW_DIMS],
    input  logic [gmi_pkg::NPTS_W-1:0]  n_pts [gmi_pkg::HW_DIMS],
    input  logic [1:0]                  nd,
    input  logic                        wr_en,
    input  logic [gmi_pkg::NODE_AW-1:0] wr_addr,
    input  logic [31:0]                 wr_data,
    output logic                        done,
    output logic signed [31:0]          interp_value,
    output logic                        result_nan
);
    import gmi_pkg::*;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_ADDR = 3'd1;
    localparam logic [2:0] M_DATA = 3'd2;
    localparam logic [2:0] M_LVL  = 3'd3;
    localparam logic [2:0] M_MUL  = 3'd4;
    localparam logic [2:0] M_SAT  = 3'd5;
    localparam logic [2:0] M_SUM  = 3'd6;

    logic [2:0]          state_reg;
    logic [NODE_AW-1:0]  base_reg, s1_reg, s2_reg;
    logic [2:0]          c_reg;
    logic [1:0]          lvl_reg;
    logic signed [63:0]  cur_reg, lo_reg, prod_s_reg;
    logic signed [63:0]  pend_reg [HW_DIMS];
    logic [HW_DIMS-1:0]  pend_v_reg;
    logic [63:0]         a_mag_reg, b_mag_reg, prod_reg;
    logic [1:0]          psh_reg;
    logic [2:0]          step_reg;
    logic [127:0]        acc_reg;
    logic                neg_reg, done_reg, nan_reg;
    logic signed [31:0]  value_reg;

    logic [NODE_AW-1:0]  raddr;
    logic [31:0]         rdata;
    logic [1:0]          verdict;
    logic [19:0]         inner_w, base_w, s2_w;
    logic [IDX_MAX_W-1:0] k1m, k2m;
    logic signed [63:0]  d_v, u_v;
    logic [31:0]         a_half, b_half;
    logic [127:0]        psh_v;
    logic [61:0]         mag_v;
    logic signed [64:0]  sum_v;

    gmi_ram #(.WIDTH(32), .DEPTH(NODE_DEPTH)) u_nodes (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        // first lane in dimension order that is not fine decides
        verdict = ST_OK;
        for (int j = HW_DIMS - 1; j >= 0; j--)
        begin
            if (2'(j) < nd && lane_res[j].status != ST_OK)
            begin
                verdict = lane_res[j].status;
            end
        end
        k1m     = (nd > 2'd1) ? lane_res[1].k : '0;
        k2m     = (nd > 2'd2) ? lane_res[2].k : '0;
        inner_w = 20'(k1m) + 20'(n_pts[1]) * 20'(k2m);
        base_w  = 20'(lane_res[0].k) + 20'(n_pts[0]) * inner_w;
        s2_w    = 20'(n_pts[0]) * 20'(n_pts[1]);
        raddr   = base_reg + (c_reg[0] ? NODE_AW'(1) : '0)
                + (c_reg[1] ? s1_reg : '0) + (c_reg[2] ? s2_reg : '0);
        d_v     = cur_reg - pend_reg[lvl_reg];
        u_v     = lane_res[lvl_reg].u;
        a_half  = step_reg[1] ? a_mag_reg[63:32] : a_mag_reg[31:0];
        b_half  = step_reg[0] ? b_mag_reg[63:32] : b_mag_reg[31:0];
        case (psh_reg)
            2'd0:    psh_v = {64'd0, prod_reg};
            2'd1:    psh_v = {32'd0, prod_reg, 32'd0};
            default: psh_v = {prod_reg, 64'd0};
        endcase
        mag_v   = acc_reg[91:30];
        sum_v   = 65'(lo_reg) + 65'(prod_s_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            done_reg   <= 1'b0;
            pend_v_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        if (verdict == ST_NAN || verdict == ST_ZERO)
                        begin
                            nan_reg   <= (verdict == ST_NAN);
                            value_reg <= '0;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            base_reg   <= base_w[NODE_AW-1:0];
                            s1_reg     <= NODE_AW'(n_pts[0]);
                            s2_reg     <= s2_w[NODE_AW-1:0];
                            c_reg      <= '0;
                            pend_v_reg <= '0;
                            state_reg  <= M_ADDR;
                        end
                    end
                end
                M_ADDR:
                begin
                    state_reg <= M_DATA;
                end
                M_DATA:
                begin
                    cur_reg   <= 64'($signed(rdata));
                    lvl_reg   <= '0;
                    state_reg <= M_LVL;
                end
                M_LVL:
                begin
                    if (lvl_reg == nd)
                    begin
                        // whole cell folded: saturate to Q16.16
                        if (cur_reg > 64'sd2147483647)
                        begin
                            value_reg <= 32'h7FFF_FFFF;
                        end
                        else if (cur_reg < -64'sd2147483648)
                        begin
                            value_reg <= 32'h8000_0000;
                        end
                        else
                        begin
                            value_reg <= cur_reg[31:0];
                        end
                        nan_reg   <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else if (pend_v_reg[lvl_reg])
                    begin
                        lo_reg              <= pend_reg[lvl_reg];
                        a_mag_reg           <= d_v[63] ? 64'(-d_v) : d_v;
                        b_mag_reg           <= u_v[63] ? 64'(-u_v) : u_v;
                        neg_reg             <= d_v[63] ^ u_v[63];
                        pend_v_reg[lvl_reg] <= 1'b0;
                        acc_reg             <= '0;
                        step_reg            <= '0;
                        state_reg           <= M_MUL;
                    end
                    else
                    begin
                        pend_reg[lvl_reg]   <= cur_reg;
                        pend_v_reg[lvl_reg] <= 1'b1;
                        c_reg               <= c_reg + 3'd1;
                        state_reg           <= M_ADDR;
                    end
                end
                M_MUL:
                begin
                    // four 32x32 partial products, each registered, then summed
                    if (step_reg != 3'd4)
                    begin
                        prod_reg <= 64'(a_half) * 64'(b_half);
                        psh_reg  <= 2'(step_reg[1]) + 2'(step_reg[0]);
                    end
                    if (step_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + psh_v;
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4)
                    begin
                        state_reg <= M_SAT;
                    end
                end
                M_SAT:
                begin
                    if (acc_reg[127:92] != '0)
                    begin
                        prod_s_reg <= neg_reg ? -(64'sd1 <<< 62) : (64'sd1 <<< 62);
                    end
                    else
                    begin
                        prod_s_reg <= neg_reg ? -$signed({2'b00, mag_v})
                                              : $signed({2'b00, mag_v});
                    end
                    state_reg <= M_SUM;
                end
                M_SUM:
                begin
                    if (sum_v > WIDE_POS)
                    begin
                        cur_reg <= 64'(WIDE_POS);
                    end
                    else if (sum_v < WIDE_NEG)
                    begin
                        cur_reg <= 64'(WIDE_NEG);
                    end
                    else
                    begin
                        cur_reg <= sum_v[63:0];
                    end
                    lvl_reg   <= lvl_reg + 2'd1;
                    state_reg <= M_LVL;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign interp_value = value_reg;
    assign result_nan   = nan_reg;
endmodule
